### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SPT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Types and fixed constants of the shadow page table translation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spt_pkg;

    localparam int VA_W        = 40;
    localparam int PAGE_W      = 28;
    localparam int PAGE_SHIFT  = 12;
    localparam int ENTRY_W     = 32;
    localparam int DIR_CNT_W   = 5;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 32;

    localparam logic [0:0] REG_DIR_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_DROP   = 2'd3
    } spt_action_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_RUN,
        ST_DROP
    } spt_state_t;

    typedef struct packed {
        logic [PAGE_W-1:0] phys_page;
        logic [1:0]        target;
        logic              ro_flag;
        logic              present;
    } spt_entry_t;

    typedef struct packed {
        spt_action_t       action;
        logic [VA_W-1:0]   vaddr;
        logic [3:0]        dir_index;
        logic              big;
        logic [9:0]        entry_index;
        logic              entry_present;
        logic [PAGE_W-1:0] phys_page;
        logic              ro_flag;
        logic [1:0]        target;
    } spt_req_t;

    typedef struct packed {
        logic [VA_W-1:0] phys_address;
        logic            fault;
        logic            hit_read_only;
        logic [1:0]      hit_target;
        logic            hit_large;
    } spt_rsp_t;

endpackage

### rtl/spt_entry_ram.sv
// ----------------------------------------------------------------------------
// spt_entry_ram
// Page table entry memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spt_entry_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [spt_pkg::ENTRY_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [spt_pkg::ENTRY_W-1:0] rdata
);

    logic [spt_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [spt_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/shadow_page_table_translate_core.sv
// ----------------------------------------------------------------------------
// shadow_page_table_translate_core
// Lookups, writes and clears each need only their beat, so a new beat can
// be accepted on every clock unless a lookup waits in the read stage while
// the output register is held by rsp_stall. A lookup reads both entry
// memories into their registered outputs, then adds the page offset into
// the output register. A drop sweeps the chosen table through that memory's
// single write port, one entry per cycle, and stalls the request channel
// until every slot of the chosen directory is cleared (a large table has a
// single slot per directory when a large page covers a whole directory).
// After reset both memories are cleared in a pass over DIR_COUNT *
// max(small slots, large slots) addresses, 16384 with the default
// parameters, during which no request is accepted; register writes work
// throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shadow_page_table_translate_core #(
    parameter int DIR_COUNT   = 16,
    parameter int DIR_SHIFT   = 22,
    parameter int SMALL_SHIFT = 12,
    parameter int LARGE_SHIFT = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spt_pkg::CFG_AW-1:0]  paddr,
    input  logic [spt_pkg::CFG_DW-1:0]  pwdata,
    output logic [spt_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  spt_pkg::spt_req_t           req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output spt_pkg::spt_rsp_t           rsp
);

    localparam int VA_W       = spt_pkg::VA_W;
    localparam int SMALL_BITS = DIR_SHIFT - SMALL_SHIFT;
    localparam int LARGE_BITS = (DIR_SHIFT > LARGE_SHIFT) ? (DIR_SHIFT - LARGE_SHIFT) : 0;
    localparam int SIDX_W     = (SMALL_BITS < 10) ? SMALL_BITS : 10;
    localparam int LIDX_W     = (LARGE_BITS < 10) ? LARGE_BITS : 10;
    localparam int LIDX_WE    = (LIDX_W > 0) ? LIDX_W : 1;
    localparam int S_SLOTS    = 1 << SIDX_W;
    localparam int L_SLOTS    = 1 << LIDX_W;
    localparam int LOFS       = (LARGE_SHIFT < DIR_SHIFT) ? LARGE_SHIFT : DIR_SHIFT;
    localparam int S_DEPTH    = DIR_COUNT * S_SLOTS;
    localparam int L_DEPTH    = DIR_COUNT * L_SLOTS;
    localparam int S_AW       = $clog2(S_DEPTH);
    localparam int L_AW       = (L_DEPTH > 1) ? $clog2(L_DEPTH) : 1;
    localparam int DIR_W      = (DIR_COUNT > 1) ? $clog2(DIR_COUNT) : 1;
    localparam int CLR_DEPTH  = (S_DEPTH > L_DEPTH) ? S_DEPTH : L_DEPTH;
    localparam int CNT_W      = $clog2(CLR_DEPTH);
    localparam int VA_DIR_W   = VA_W - DIR_SHIFT;
    localparam int S_HI_W     = SMALL_BITS - SIDX_W;
    localparam int L_HI_W     = LARGE_BITS - LIDX_W;

    localparam logic [VA_W-1:0] S_HI_MASK   = VA_W'((64'(1) << S_HI_W) - 64'(1));
    localparam logic [VA_W-1:0] L_HI_MASK   = VA_W'((64'(1) << L_HI_W) - 64'(1));
    localparam logic [VA_W-1:0] S_OFS_MASK  = VA_W'((64'(1) << SMALL_SHIFT) - 64'(1));
    localparam logic [VA_W-1:0] L_OFS_MASK  = VA_W'((64'(1) << LOFS) - 64'(1));
    localparam logic [LIDX_WE-1:0] L_IDX_MASK = LIDX_WE'((64'(1) << LIDX_W) - 64'(1));
    localparam logic [CNT_W-1:0] CLR_LAST   = CNT_W'(CLR_DEPTH - 1);
    localparam logic [CNT_W-1:0] S_LAST     = CNT_W'(S_SLOTS - 1);
    localparam logic [CNT_W-1:0] L_LAST     = CNT_W'(L_SLOTS - 1);

    // Control state
    spt_pkg::spt_state_t              state_reg, state_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [spt_pkg::DIR_CNT_W-1:0]    dir_count_reg, dir_count_next;
    logic [DIR_COUNT-1:0]             small_live_reg, small_live_next;
    logic [DIR_COUNT-1:0]             large_live_reg, large_live_next;
    logic                             s1_valid_reg, s1_valid_next;
    logic                             rsp_valid_reg, rsp_valid_next;

    // Payload state
    logic [DIR_W-1:0]                 drop_dir_reg;
    logic                             drop_big_reg;
    logic [VA_W-1:0]                  s1_va_reg;
    logic                             s1_dir_ok_reg;
    logic                             s1_s_ok_reg;
    logic                             s1_l_ok_reg;
    spt_pkg::spt_rsp_t                rsp_reg, rsp_next;

    // Request decode
    logic                             accept;
    logic                             take_ok;
    logic                             out_free;
    logic                             sweep_last;
    logic                             look_go;
    logic                             wr_go;
    logic                             drop_go;
    logic [VA_DIR_W-1:0]              va_dir;
    logic [DIR_W-1:0]                 look_dir;
    logic                             look_dir_ok;
    logic [SIDX_W-1:0]                look_sidx;
    logic [LIDX_WE-1:0]               look_lidx;
    logic                             look_s_in;
    logic                             look_l_in;
    logic [DIR_W-1:0]                 wr_dir;
    logic                             wr_dir_ok;
    logic                             wr_s_in;
    logic                             wr_l_in;
    logic [SIDX_W-1:0]                wr_sidx;
    logic [LIDX_WE-1:0]               wr_lidx;
    spt_pkg::spt_entry_t              wr_entry;

    // Memory ports
    logic                             s_we;
    logic [S_AW-1:0]                  s_waddr;
    logic [spt_pkg::ENTRY_W-1:0]      s_wdata;
    logic [S_AW-1:0]                  s_raddr;
    logic [spt_pkg::ENTRY_W-1:0]      s_rdata;
    logic                             l_we;
    logic [L_AW-1:0]                  l_waddr;
    logic [spt_pkg::ENTRY_W-1:0]      l_wdata;
    logic [L_AW-1:0]                  l_raddr;
    logic [spt_pkg::ENTRY_W-1:0]      l_rdata;

    // Result path
    spt_pkg::spt_entry_t              s_ent;
    spt_pkg::spt_entry_t              l_ent;
    logic                             s_hit;
    logic                             l_hit;
    logic [spt_pkg::PAGE_W-1:0]       sel_page;
    logic [VA_W-1:0]                  sel_ofs;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb
    begin
        dir_count_next = dir_count_reg;
        if (psel && penable && pwrite && (paddr[2] == spt_pkg::REG_DIR_COUNT))
        begin
            dir_count_next = pwdata[spt_pkg::DIR_CNT_W-1:0];
        end
    end

    always_comb
    begin
        case (paddr[2])
            spt_pkg::REG_DIR_COUNT: prdata = spt_pkg::CFG_DW'(dir_count_reg);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------------
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !take_ok;
    assign accept = req_valid && take_ok;

    assign va_dir      = VA_DIR_W'(req.vaddr >> DIR_SHIFT);
    assign look_dir    = DIR_W'(va_dir);
    assign look_dir_ok = (va_dir < VA_DIR_W'(dir_count_reg)) && (va_dir < VA_DIR_W'(DIR_COUNT));
    assign look_sidx   = SIDX_W'(req.vaddr >> SMALL_SHIFT);
    assign look_lidx   = LIDX_WE'(req.vaddr >> LOFS) & L_IDX_MASK;
    assign look_s_in   = ((req.vaddr >> (SMALL_SHIFT + SIDX_W)) & S_HI_MASK) == '0;
    assign look_l_in   = ((req.vaddr >> (LOFS + LIDX_W)) & L_HI_MASK) == '0;

    assign wr_dir    = DIR_W'(req.dir_index);
    assign wr_dir_ok = 32'(req.dir_index) < DIR_COUNT;
    assign wr_s_in   = 32'(req.entry_index) < S_SLOTS;
    assign wr_l_in   = 32'(req.entry_index) < L_SLOTS;
    assign wr_sidx   = SIDX_W'(req.entry_index);
    assign wr_lidx   = LIDX_WE'(req.entry_index) & L_IDX_MASK;

    always_comb
    begin
        look_go  = 1'b0;
        wr_go    = 1'b0;
        drop_go  = 1'b0;
        wr_entry = '0;
        case (req.action)
            spt_pkg::ACT_LOOKUP:
            begin
                look_go = accept;
            end
            spt_pkg::ACT_WRITE:
            begin
                wr_go              = accept && wr_dir_ok;
                wr_entry.present   = req.entry_present;
                wr_entry.ro_flag   = req.ro_flag;
                wr_entry.target    = req.target;
                wr_entry.phys_page = req.phys_page;
            end
            spt_pkg::ACT_CLEAR:
            begin
                wr_go = accept && wr_dir_ok;
            end
            spt_pkg::ACT_DROP:
            begin
                drop_go = accept && wr_dir_ok;
            end
            default:
            begin
                look_go = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        small_live_next = small_live_reg;
        large_live_next = large_live_reg;
        if (wr_go)
        begin
            if (!req.big && wr_s_in)
            begin
                small_live_next[wr_dir] = 1'b1;
            end
            if (req.big && wr_l_in)
            begin
                large_live_next[wr_dir] = 1'b1;
            end
        end
        if (drop_go)
        begin
            if (req.big)
            begin
                large_live_next[wr_dir] = 1'b0;
            end
            else
            begin
                small_live_next[wr_dir] = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer: clearing pass, run, drop sweep
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            spt_pkg::ST_INIT,
            spt_pkg::ST_DROP:
            begin
                if (sweep_last)
                begin
                    state_next = spt_pkg::ST_RUN;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
            end
            spt_pkg::ST_RUN:
            begin
                cnt_next = '0;
                if (drop_go)
                begin
                    state_next = spt_pkg::ST_DROP;
                end
            end
            default:
            begin
                state_next = spt_pkg::ST_INIT;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        take_ok    = 1'b0;
        sweep_last = 1'b0;
        s_we       = 1'b0;
        s_waddr    = S_AW'((32'(wr_dir) << SIDX_W) | 32'(wr_sidx));
        s_wdata    = wr_entry;
        l_we       = 1'b0;
        l_waddr    = L_AW'((32'(wr_dir) << LIDX_W) | 32'(wr_lidx));
        l_wdata    = wr_entry;
        case (state_reg)
            spt_pkg::ST_INIT:
            begin
                sweep_last = cnt_reg == CLR_LAST;
                s_we       = {1'b0, cnt_reg} < (CNT_W + 1)'(S_DEPTH);
                s_waddr    = S_AW'(cnt_reg);
                s_wdata    = '0;
                l_we       = {1'b0, cnt_reg} < (CNT_W + 1)'(L_DEPTH);
                l_waddr    = L_AW'(cnt_reg);
                l_wdata    = '0;
            end
            spt_pkg::ST_DROP:
            begin
                sweep_last = cnt_reg == (drop_big_reg ? L_LAST : S_LAST);
                s_we       = !drop_big_reg;
                s_waddr    = S_AW'((32'(drop_dir_reg) << SIDX_W) | 32'(SIDX_W'(cnt_reg)));
                s_wdata    = '0;
                l_we       = drop_big_reg;
                l_waddr    = L_AW'((32'(drop_dir_reg) << LIDX_W)
                                   | 32'(LIDX_WE'(cnt_reg) & L_IDX_MASK));
                l_wdata    = '0;
            end
            spt_pkg::ST_RUN:
            begin
                take_ok = !s1_valid_reg || out_free;
                s_we    = wr_go && !req.big && wr_s_in;
                l_we    = wr_go && req.big && wr_l_in;
            end
            default:
            begin
                take_ok = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Entry memories
    // ------------------------------------------------------------------------
    assign s_raddr = S_AW'((32'(look_dir) << SIDX_W) | 32'(look_sidx));
    assign l_raddr = L_AW'((32'(look_dir) << LIDX_W) | 32'(look_lidx));

    spt_entry_ram #(
        .DEPTH (S_DEPTH),
        .AW    (S_AW)
    ) u_small_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (look_go),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    spt_entry_ram #(
        .DEPTH (L_DEPTH),
        .AW    (L_AW)
    ) u_large_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (look_go),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // ------------------------------------------------------------------------
    // Result stage
    // ------------------------------------------------------------------------
    assign s_ent = spt_pkg::spt_entry_t'(s_rdata);
    assign l_ent = spt_pkg::spt_entry_t'(l_rdata);
    assign s_hit = s1_dir_ok_reg && s1_s_ok_reg && s_ent.present;
    assign l_hit = s1_dir_ok_reg && s1_l_ok_reg && l_ent.present;

    always_comb
    begin
        sel_page = s_hit ? s_ent.phys_page : l_ent.phys_page;
        sel_ofs  = s1_va_reg & (s_hit ? S_OFS_MASK : L_OFS_MASK);
        rsp_next.phys_address = VA_W'((VA_W'(sel_page) << spt_pkg::PAGE_SHIFT) + sel_ofs);
        rsp_next.fault         = 1'b0;
        rsp_next.hit_read_only = s_hit ? s_ent.ro_flag : l_ent.ro_flag;
        rsp_next.hit_target    = s_hit ? s_ent.target : l_ent.target;
        rsp_next.hit_large     = !s_hit;
        if (!s_hit && !l_hit)
        begin
            rsp_next.phys_address  = '1;
            rsp_next.fault         = 1'b1;
            rsp_next.hit_read_only = 1'b0;
            rsp_next.hit_target    = '0;
            rsp_next.hit_large     = 1'b0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = look_go;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        rsp_valid_next = out_free ? s1_valid_reg : rsp_valid_reg;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spt_pkg::ST_INIT;
            cnt_reg        <= '0;
            dir_count_reg  <= '0;
            small_live_reg <= '0;
            large_live_reg <= '0;
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            dir_count_reg  <= dir_count_next;
            small_live_reg <= small_live_next;
            large_live_reg <= large_live_next;
            s1_valid_reg   <= s1_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drop_go)
        begin
            drop_dir_reg <= wr_dir;
            drop_big_reg <= req.big;
        end
        if (look_go)
        begin
            s1_va_reg     <= req.vaddr;
            s1_dir_ok_reg <= look_dir_ok;
            s1_s_ok_reg   <= look_dir_ok && small_live_reg[look_dir] && look_s_in;
            s1_l_ok_reg   <= look_dir_ok && large_live_reg[look_dir] && look_l_in;
        end
        if (out_free && s1_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

### rtl/spt_checker.sv
// ----------------------------------------------------------------------------
// spt_checker
// Port-level checks of the translation core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spt_checker #(
    parameter int DIR_COUNT = 16
) (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input spt_pkg::spt_req_t req,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input spt_pkg::spt_rsp_t rsp
);

    `SPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "response beat dropped while stalled")
    `SPT_ASSERT_IMPL(a_fault_shape, rsp_valid && rsp.fault, (rsp.phys_address == '1) && !rsp.hit_read_only && (rsp.hit_target == 2'd0) && !rsp.hit_large, "fault beat carries hit data")
    `SPT_ASSERT_IMPL(a_rsp_origin, $rose(rsp_valid), $past(req_valid && !req_stall && (req.action == spt_pkg::ACT_LOOKUP), 2), "response beat without a lookup two cycles earlier")
    `SPT_ASSERT_NEXT(a_drop_stalls, req_valid && !req_stall && (req.action == spt_pkg::ACT_DROP) && (32'(req.dir_index) < DIR_COUNT), req_stall, "request taken during a table drop")

endmodule

bind shadow_page_table_translate_core spt_checker #(.DIR_COUNT(DIR_COUNT)) u_spt_checker (.*);

### tb/tb_shadow_page_table_translate_core.sv
// ----------------------------------------------------------------------------
// tb_shadow_page_table_translate_core
// Self-checking bench for the two-level translation core. A local copy of the
// directory tables predicts every lookup at the moment its beat is accepted.
// Directed beats cover page extremes, small-to-large fallback, clears, drops,
// ignored writes and the directory gate. Random phases then run under several
// directory counts with random idling on both channels and a long receiver
// hold that backs the core up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shadow_page_table_translate_core;

    localparam int VA_W          = spt_pkg::VA_W;
    localparam int PAGE_W        = spt_pkg::PAGE_W;
    localparam int PAGE_SHIFT    = spt_pkg::PAGE_SHIFT;
    localparam int CFG_AW        = spt_pkg::CFG_AW;
    localparam int CFG_DW        = spt_pkg::CFG_DW;
    localparam int DIR_CNT_W     = spt_pkg::DIR_CNT_W;
    localparam int DIRS          = 16;
    localparam int DIR_SHIFT     = 22;
    localparam int SMALL_SHIFT   = 12;
    localparam int LARGE_SHIFT   = 17;
    localparam int SMALL_BITS    = DIR_SHIFT - SMALL_SHIFT;
    localparam int LARGE_BITS    = DIR_SHIFT - LARGE_SHIFT;
    localparam int SMALL_SLOTS   = 1 << SMALL_BITS;
    localparam int LARGE_SLOTS   = 1 << LARGE_BITS;
    localparam int SWEEP_WAIT    = SMALL_SLOTS + 76;
    localparam int HOLD_CYCLES   = 400;
    localparam int RECENT_DEPTH  = 48;
    localparam int LIMIT_CYCLES  = 600000;

    localparam logic [CFG_AW-1:0] DIR_COUNT_ADDR = CFG_AW'(spt_pkg::REG_DIR_COUNT) << 2;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;
    logic              req_valid;
    logic              req_stall;
    spt_pkg::spt_req_t req;
    logic              rsp_valid;
    logic              rsp_stall;
    spt_pkg::spt_rsp_t rsp;

    logic [DIR_CNT_W-1:0] dir_count_m;
    logic                 small_live [DIRS];
    logic                 large_live [DIRS];
    spt_pkg::spt_entry_t  small_tab [DIRS][SMALL_SLOTS];
    spt_pkg::spt_entry_t  large_tab [DIRS][LARGE_SLOTS];

    spt_pkg::spt_rsp_t pending_translations [$];
    logic [14:0]       recent_keys [$];
    spt_pkg::spt_rsp_t oldest_translation;

    int   errors;
    int   cycle_count;
    bit   burst_mode;
    logic rx_hold;
    int   stall_left;
    int   calm_left;
    int   stall_roll;
    event hold_kick;

    shadow_page_table_translate_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: run stopped after %0d cycles", $time, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void reset_tables();
        int d;
        int i;
        dir_count_m = '0;
        for (d = 0; d < DIRS; d++)
        begin
            small_live[d] = 1'b0;
            large_live[d] = 1'b0;
            for (i = 0; i < SMALL_SLOTS; i++)
                small_tab[d][i] = '0;
            for (i = 0; i < LARGE_SLOTS; i++)
                large_tab[d][i] = '0;
        end
    endfunction

    function automatic spt_pkg::spt_rsp_t translate_va(input logic [VA_W-1:0] va);
        logic [VA_W-DIR_SHIFT-1:0] dir;
        logic [3:0]                d;
        logic [SMALL_BITS-1:0]     sidx;
        logic [LARGE_BITS-1:0]     lidx;
        spt_pkg::spt_entry_t       e;
        spt_pkg::spt_rsp_t         r;
        dir  = va[VA_W-1:DIR_SHIFT];
        d    = dir[3:0];
        sidx = va[DIR_SHIFT-1:SMALL_SHIFT];
        lidx = va[DIR_SHIFT-1:LARGE_SHIFT];
        r.phys_address  = '1;
        r.fault         = 1'b1;
        r.hit_read_only = 1'b0;
        r.hit_target    = 2'b00;
        r.hit_large     = 1'b0;
        if (dir < dir_count_m && dir < DIRS)
        begin
            e = small_tab[d][sidx];
            if (small_live[d] && e.present)
            begin
                r.phys_address  = {e.phys_page, PAGE_SHIFT'(0)} + VA_W'(va[SMALL_SHIFT-1:0]);
                r.fault         = 1'b0;
                r.hit_read_only = e.ro_flag;
                r.hit_target    = e.target;
                return r;
            end
            e = large_tab[d][lidx];
            if (large_live[d] && e.present)
            begin
                r.phys_address  = {e.phys_page, PAGE_SHIFT'(0)} + VA_W'(va[LARGE_SHIFT-1:0]);
                r.fault         = 1'b0;
                r.hit_read_only = e.ro_flag;
                r.hit_target    = e.target;
                r.hit_large     = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void apply_table_update(input spt_pkg::spt_req_t r);
        spt_pkg::spt_entry_t e;
        int                  i;
        e = '0;
        if (r.action == spt_pkg::ACT_DROP)
        begin
            if (r.big)
            begin
                large_live[r.dir_index] = 1'b0;
                for (i = 0; i < LARGE_SLOTS; i++)
                    large_tab[r.dir_index][i] = '0;
            end
            else
            begin
                small_live[r.dir_index] = 1'b0;
                for (i = 0; i < SMALL_SLOTS; i++)
                    small_tab[r.dir_index][i] = '0;
            end
            return;
        end
        if (r.action == spt_pkg::ACT_WRITE)
        begin
            e.present   = r.entry_present;
            e.ro_flag   = r.ro_flag;
            e.target    = r.target;
            e.phys_page = r.phys_page;
        end
        if (r.big)
        begin
            if (r.entry_index < LARGE_SLOTS)
            begin
                large_live[r.dir_index] = 1'b1;
                large_tab[r.dir_index][r.entry_index[LARGE_BITS-1:0]] = e;
            end
        end
        else
        begin
            small_live[r.dir_index] = 1'b1;
            small_tab[r.dir_index][r.entry_index] = e;
        end
    endfunction

    function automatic logic [VA_W-1:0] random_va();
        return VA_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [VA_W-1:0] va_of(input logic [3:0] d, input logic big,
                                              input logic [9:0] idx,
                                              input logic [VA_W-1:0] ofs);
        logic [VA_W-1:0] va;
        va = '0;
        va[DIR_SHIFT +: 4] = d;
        if (big)
        begin
            va[LARGE_SHIFT +: LARGE_BITS] = idx[LARGE_BITS-1:0];
            va[LARGE_SHIFT-1:0]           = ofs[LARGE_SHIFT-1:0];
        end
        else
        begin
            va[SMALL_SHIFT +: SMALL_BITS] = idx;
            va[SMALL_SHIFT-1:0]           = ofs[SMALL_SHIFT-1:0];
        end
        return va;
    endfunction

    function automatic spt_pkg::spt_req_t random_req();
        spt_pkg::spt_req_t r;
        r.action          = spt_pkg::spt_action_t'($urandom_range(0, 3));
        r.vaddr           = random_va();
        r.dir_index       = 4'($urandom());
        r.big             = 1'($urandom());
        r.entry_index     = 10'($urandom());
        r.entry_present   = 1'($urandom());
        r.phys_page       = PAGE_W'($urandom());
        r.ro_flag         = 1'($urandom());
        r.target          = 2'($urandom());
        return r;
    endfunction

    function automatic void remember_key(input logic [3:0] d, input logic big,
                                         input logic [9:0] idx);
        recent_keys.push_back({d, big, idx});
        if (recent_keys.size() > RECENT_DEPTH)
            void'(recent_keys.pop_front());
    endfunction

    function automatic int pick_gap();
        int roll;
        if (burst_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Each call starts and ends at a rising edge; the table copy is updated
    // only once the beat has actually been taken.
    task automatic send_beat(input spt_pkg::spt_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (r.action == spt_pkg::ACT_LOOKUP)
            pending_translations.push_back(translate_va(r.vaddr));
        else
            apply_table_update(r);
    endtask

    task automatic send_lookup(input logic [VA_W-1:0] va);
        spt_pkg::spt_req_t r;
        r = random_req();
        r.action = spt_pkg::ACT_LOOKUP;
        r.vaddr  = va;
        send_beat(r);
    endtask

    task automatic send_write(input logic [3:0] d, input logic big, input logic [9:0] idx,
                              input logic present, input logic [PAGE_W-1:0] page,
                              input logic ro, input logic [1:0] tgt);
        spt_pkg::spt_req_t r;
        r = random_req();
        r.action        = spt_pkg::ACT_WRITE;
        r.dir_index     = d;
        r.big           = big;
        r.entry_index   = idx;
        r.entry_present = present;
        r.phys_page     = page;
        r.ro_flag       = ro;
        r.target        = tgt;
        send_beat(r);
        remember_key(d, big, idx);
    endtask

    task automatic send_erase(input spt_pkg::spt_action_t act, input logic [3:0] d,
                              input logic big, input logic [9:0] idx);
        spt_pkg::spt_req_t r;
        r = random_req();
        r.action      = act;
        r.dir_index   = d;
        r.big         = big;
        r.entry_index = idx;
        send_beat(r);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_translations.size() != 0)
            @(posedge clk);
    endtask

    // A drop may still be sweeping its table after the last result is back.
    task automatic settle();
        wait_drained();
        repeat (SWEEP_WAIT) @(posedge clk);
    endtask

    task automatic set_directory_count(input logic [DIR_CNT_W-1:0] count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DIR_COUNT_ADDR;
        pwdata  <= CFG_DW'(count);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        dir_count_m = count;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[DIR_CNT_W-1:0] !== count)
        begin
            errors++;
            $display("%0t: directory_count readback expected %0d actual %0d",
                     $time, count, prdata[DIR_CNT_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_lookup('0);
        send_lookup('1);
        send_write(4'd0, 1'b0, 10'd0, 1'b1, PAGE_W'(28'h0ABCDEF), 1'b0, 2'd1);
        send_lookup(va_of(4'd0, 1'b0, 10'd0, 40'h123));
        settle();
        set_directory_count(5'(DIRS));
        send_lookup(va_of(4'd0, 1'b0, 10'd0, 40'h123));
    endtask

    task automatic test_directed_entries();
        send_write(4'd0, 1'b0, 10'd1023, 1'b1, '1, 1'b1, 2'd3);
        send_lookup(va_of(4'd0, 1'b0, 10'd1023, '1));
        send_write(4'd15, 1'b1, 10'd31, 1'b1, '1, 1'b0, 2'd2);
        send_lookup(va_of(4'd15, 1'b1, 10'd31, '1));
        send_write(4'd3, 1'b1, 10'd1023, 1'b1, PAGE_W'(28'h1234567), 1'b1, 2'd3);
        send_lookup(va_of(4'd3, 1'b1, 10'd1023, 40'h0F0F));
        send_write(4'd1, 1'b1, 10'd0, 1'b1, PAGE_W'(28'd5), 1'b1, 2'd1);
        send_write(4'd1, 1'b0, 10'd0, 1'b0, PAGE_W'(28'd9), 1'b1, 2'd2);
        send_lookup(va_of(4'd1, 1'b0, 10'd0, 40'h0ABC));
        send_write(4'd1, 1'b0, 10'd0, 1'b1, '0, 1'b0, 2'd0);
        send_lookup(va_of(4'd1, 1'b0, 10'd0, 40'h0ABC));
        send_erase(spt_pkg::ACT_CLEAR, 4'd1, 1'b0, 10'd0);
        send_lookup(va_of(4'd1, 1'b0, 10'd0, 40'h1FFFF));
        send_erase(spt_pkg::ACT_CLEAR, 4'd1, 1'b1, 10'd0);
        send_lookup(va_of(4'd1, 1'b1, 10'd0, 40'h00001));
        send_erase(spt_pkg::ACT_DROP, 4'd0, 1'b0, 10'd0);
        send_lookup(va_of(4'd0, 1'b0, 10'd1023, '0));
        send_erase(spt_pkg::ACT_DROP, 4'd15, 1'b1, 10'd0);
        send_lookup(va_of(4'd15, 1'b1, 10'd31, '0));
        send_lookup('1);
        send_lookup(VA_W'(DIRS) << DIR_SHIFT);
    endtask

    task automatic test_directory_gate();
        send_write(4'd0, 1'b0, 10'd0, 1'b1, PAGE_W'(28'h0000777), 1'b0, 2'd2);
        settle();
        set_directory_count(5'd1);
        send_write(4'd5, 1'b0, 10'd7, 1'b1, PAGE_W'(28'h0FEDCBA), 1'b1, 2'd1);
        send_lookup(va_of(4'd0, 1'b0, 10'd0, 40'h321));
        send_lookup(va_of(4'd5, 1'b0, 10'd7, 40'h321));
        settle();
        set_directory_count(5'd6);
        send_lookup(va_of(4'd5, 1'b0, 10'd7, 40'hFFF));
        send_lookup(va_of(4'd6, 1'b0, 10'd7, 40'hFFF));
        settle();
        set_directory_count(5'(DIRS));
    endtask

    task automatic random_beat();
        spt_pkg::spt_req_t r;
        int                roll;
        logic [14:0]       k;
        r = random_req();
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            r.action = spt_pkg::ACT_LOOKUP;
            k = recent_keys.size() != 0 ? recent_keys[$urandom_range(0, recent_keys.size() - 1)]
                                        : 15'($urandom());
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 9) >= 7)
                    k = 15'($urandom());
                r.vaddr = va_of(k[14:11], k[10], k[9:0], random_va());
                if ($urandom_range(0, 7) == 0)
                    r.vaddr[VA_W-1:DIR_SHIFT+4] = (VA_W-DIR_SHIFT-4)'(random_va());
            end
        end
        else if (roll < 88)
        begin
            r.action        = spt_pkg::ACT_WRITE;
            r.entry_present = $urandom_range(0, 99) < 85;
            if (r.big && $urandom_range(0, 9) != 0)
                r.entry_index = 10'($urandom_range(0, LARGE_SLOTS - 1));
            remember_key(r.dir_index, r.big, r.entry_index);
        end
        else if (roll < 96)
        begin
            r.action = spt_pkg::ACT_CLEAR;
            if (recent_keys.size() != 0 && $urandom_range(0, 9) < 7)
            begin
                k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                r.dir_index   = k[14:11];
                r.big         = k[10];
                r.entry_index = k[9:0];
            end
        end
        else
        begin
            r.action = spt_pkg::ACT_DROP;
            r.big    = $urandom_range(0, 9) < 7;
        end
        send_beat(r);
    endtask

    task automatic test_back_pressure();
        int i;
        -> hold_kick;
        burst_mode = 1'b1;
        for (i = 0; i < 60; i++)
            random_beat();
        burst_mode = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int counts [8];
        int p;
        int i;
        counts = '{16, 9, 0, 16, 1, 16, 4, 16};
        for (p = 0; p < 8; p++)
        begin
            settle();
            set_directory_count(5'(counts[p]));
            for (i = 0; i < 70; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
                random_beat();
            end
        end
    endtask

    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(hold_kick);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (rx_hold)
            rsp_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (calm_left > 0)
        begin
            rsp_stall <= 1'b0;
            calm_left = calm_left - 1;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 20)
            begin
                rsp_stall <= 1'b1;
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 75)
                    stall_left = $urandom_range(0, 2);
                else if (stall_roll < 95)
                    stall_left = $urandom_range(3, 11);
                else
                    stall_left = $urandom_range(19, 59);
            end
            else
            begin
                rsp_stall <= 1'b0;
                if (stall_roll < 23)
                    calm_left = $urandom_range(30, 120);
            end
        end
    end

    task automatic report_field(input string field, input logic [VA_W-1:0] want_v,
                                input logic [VA_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, field, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_translations.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing pending, actual %h", $time, rsp);
            end
            else
            begin
                oldest_translation = pending_translations.pop_front();
                report_field("phys_address", oldest_translation.phys_address, rsp.phys_address);
                report_field("fault", VA_W'(oldest_translation.fault), VA_W'(rsp.fault));
                report_field("hit_read_only", VA_W'(oldest_translation.hit_read_only),
                             VA_W'(rsp.hit_read_only));
                report_field("hit_target", VA_W'(oldest_translation.hit_target),
                             VA_W'(rsp.hit_target));
                report_field("hit_large", VA_W'(oldest_translation.hit_large),
                             VA_W'(rsp.hit_large));
            end
        end
    end

    initial
    begin
        errors      = 0;
        burst_mode  = 1'b0;
        stall_left  = 0;
        calm_left   = 0;
        reset_tables();
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed_entries();
        test_directory_gate();
        test_back_pressure();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_translations.size() != 0)
        begin
            errors++;
            $display("%0t: %0d translations never arrived", $time, pending_translations.size());
        end
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
